@@ src/multirom_cart_bank_mapper_defines.svh @@
// ----------------------------------------------------------------------------
// Multi-ROM cart bank mapper assertion macros
// Shared concurrent assertion forms, clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MULTIROM_CART_BANK_MAPPER_DEFINES_SVH
`define MULTIROM_CART_BANK_MAPPER_DEFINES_SVH

// Same-cycle implication.
`define MCBM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mapper assertion failed");

// Next-cycle implication.
`define MCBM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mapper assertion failed");

`endif

@@ src/mcbm_pkg.sv @@
// ----------------------------------------------------------------------------
// Multi-ROM cart bank mapper package
// Request/result types, key bytes, address windows and mode codes.
// ----------------------------------------------------------------------------
package mcbm_pkg;

    localparam int unsigned ADDR_W     = 16;
    localparam int unsigned DATA_W     = 8;
    localparam int unsigned ROM_ADDR_W = 23;
    localparam int unsigned OFFSET_W   = 14;                 // 16 KiB bank
    localparam int unsigned BANK_W     = ROM_ADDR_W - OFFSET_W;

    // Access kind
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Key bytes
    localparam logic [DATA_W-1:0] KEY_BYTE_BASE = 8'hA5;
    localparam logic [DATA_W-1:0] KEY_BYTE_BANK = 8'h98;

    // Address windows
    localparam logic [ADDR_W-1:0] KEY_LO   = 16'h1000;
    localparam logic [ADDR_W-1:0] KEY_HI   = 16'h1FFF;
    localparam logic [ADDR_W-1:0] SEL_LO   = 16'h2000;
    localparam logic [ADDR_W-1:0] SEL_HI   = 16'h3FFF;
    localparam logic [ADDR_W-1:0] LATCH_LO = 16'h7000;
    localparam logic [ADDR_W-1:0] LATCH_HI = 16'h7FFF;
    localparam logic [ADDR_W-1:0] ROM_HI   = 16'h7FFF;
    localparam logic [ADDR_W-1:0] BANK_SIZE = 16'h4000;

    // Key mode, one-hot
    typedef enum logic [2:0] {
        KEY_NONE = 3'b001,
        KEY_BASE = 3'b010,
        KEY_BANK = 3'b100
    } t_key_mode;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] bus_address;
        logic [DATA_W-1:0] write_data;
    } t_req;

    typedef struct packed {
        logic [ROM_ADDR_W-1:0] rom_byte_address;
        logic                  rom_hit;
        logic                  game_mode;
    } t_result;

endpackage

@@ src/mcbm_core.sv @@
// ----------------------------------------------------------------------------
// Multi-ROM cart bank mapper core
// Mapper state registers and the single-pass read map / write decode.
// ----------------------------------------------------------------------------
module mcbm_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  mcbm_pkg::t_req    i_req,
    output mcbm_pkg::t_result o_res
);

    mcbm_pkg::t_key_mode r_key_mode, n_key_mode;
    logic                r_in_game, n_in_game;
    logic [mcbm_pkg::DATA_W-1:0] r_pending_base, n_pending_base;
    logic [mcbm_pkg::DATA_W-1:0] r_game_base, n_game_base;
    logic [mcbm_pkg::DATA_W-1:0] r_bank_select, n_bank_select;

    logic [mcbm_pkg::BANK_W-1:0] bank;
    logic [mcbm_pkg::ADDR_W-1:0] addr;
    logic [mcbm_pkg::DATA_W-1:0] data;

    assign addr = i_req.bus_address;
    assign data = i_req.write_data;

    // Bank for a read; upper half uses the switchable bank
    always_comb begin
        if (addr < mcbm_pkg::BANK_SIZE) begin
            bank = r_in_game ? {1'b0, r_game_base} : '0;
        end else if (r_in_game) begin
            bank = {1'b0, r_game_base} + {1'b0, r_bank_select};
        end else if (r_bank_select == '0) begin
            bank = mcbm_pkg::BANK_W'(1);
        end else begin
            bank = {1'b0, r_bank_select};
        end
    end

    always_comb begin
        n_key_mode     = r_key_mode;
        n_in_game      = r_in_game;
        n_pending_base = r_pending_base;
        n_game_base    = r_game_base;
        n_bank_select  = r_bank_select;
        o_res          = '0;

        if (i_req.op == mcbm_pkg::OP_WRITE) begin
            priority if (addr >= mcbm_pkg::KEY_LO && addr <= mcbm_pkg::KEY_HI) begin
                priority if (data == mcbm_pkg::KEY_BYTE_BASE) begin
                    n_key_mode = mcbm_pkg::KEY_BASE;
                end else if (data == mcbm_pkg::KEY_BYTE_BANK) begin
                    n_key_mode = mcbm_pkg::KEY_BANK;
                end else begin
                    n_key_mode = mcbm_pkg::KEY_NONE;
                end
            end else if (addr >= mcbm_pkg::SEL_LO && addr <= mcbm_pkg::SEL_HI) begin
                unique case (r_key_mode)
                    mcbm_pkg::KEY_BASE: n_pending_base = data;
                    mcbm_pkg::KEY_BANK: n_bank_select  = data;
                    default: ;
                endcase
            end else if (addr >= mcbm_pkg::LATCH_LO && addr <= mcbm_pkg::LATCH_HI) begin
                if (r_key_mode == mcbm_pkg::KEY_BASE) begin
                    n_in_game     = 1'b1;
                    n_game_base   = r_pending_base;
                    n_bank_select = '0;
                end
            end else begin
            end
        end else if (addr <= mcbm_pkg::ROM_HI) begin
            o_res.rom_byte_address = {bank, addr[mcbm_pkg::OFFSET_W-1:0]};
            o_res.rom_hit          = 1'b1;
        end

        o_res.game_mode = n_in_game;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_mode     <= mcbm_pkg::KEY_NONE;
            r_in_game      <= 1'b0;
            r_pending_base <= '0;
            r_game_base    <= '0;
            r_bank_select  <= mcbm_pkg::DATA_W'(1);
        end else if (i_fire) begin
            r_key_mode     <= n_key_mode;
            r_in_game      <= n_in_game;
            r_pending_base <= n_pending_base;
            r_game_base    <= n_game_base;
            r_bank_select  <= n_bank_select;
        end
    end

endmodule

@@ src/multirom_cart_bank_mapper.sv @@
// ----------------------------------------------------------------------------
// Multi-ROM cart bank mapper
// Maps cartridge bus reads to ROM byte addresses and decodes mapper writes.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: i_req_valid with i_op / i_bus_address / i_write_data;
//   the block holds o_req_stall high when it cannot take a request.
//   Result channel: o_res_valid with o_rom_byte_address / o_rom_hit /
//   o_game_mode; the receiver holds i_res_stall high to hold the result.
//   Every request, read or write, gives exactly one result.
// Path: an accepted request is loaded into the input register, then into
//   the result register through the map/decode logic once that register
//   is free.
// Throughput: one request per cycle while the result is not held; the rate
//   is set by the single-pass decode and bank add between the two registers.
// Reset (i_rst_n low, synchronous): both stages empty, no key mode, game
//   mode off, pending base and game base 0, bank select 1.
// Stall: while the result is held, one more request waits in the input
//   register; a third request sees o_req_stall until the result is taken.
// ----------------------------------------------------------------------------
`include "multirom_cart_bank_mapper_defines.svh"

module multirom_cart_bank_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_req_valid,
    output logic        o_req_stall,
    input  logic        i_op,
    input  logic [15:0] i_bus_address,
    input  logic [7:0]  i_write_data,
    // result channel
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [22:0] o_rom_byte_address,
    output logic        o_rom_hit,
    output logic        o_game_mode
);

    // input register
    logic              r_req_valid, n_req_valid;
    mcbm_pkg::t_req    r_req;

    // result register
    logic              r_res_valid, n_res_valid;
    mcbm_pkg::t_result r_res;
    mcbm_pkg::t_result core_res;

    logic out_free;   // result register can load this cycle
    logic fire;       // request moves from input register into result
    logic req_take;   // new request accepted

    assign out_free    = !r_res_valid || !i_res_stall;
    assign fire        = r_req_valid && out_free;
    assign o_req_stall = r_req_valid && !out_free;
    assign req_take    = i_req_valid && !o_req_stall;

    // State updates only on fire, so requests apply in order.
    mcbm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (r_req),
        .o_res   (core_res)
    );

    always_comb begin
        if (req_take) begin
            n_req_valid = 1'b1;
        end else if (fire) begin
            n_req_valid = 1'b0;
        end else begin
            n_req_valid = r_req_valid;
        end

        if (fire) begin
            n_res_valid = 1'b1;
        end else if (!i_res_stall) begin
            n_res_valid = 1'b0;
        end else begin
            n_res_valid = r_res_valid;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_req_valid <= n_req_valid;
            r_res_valid <= n_res_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_req <= '{op: i_op, bus_address: i_bus_address, write_data: i_write_data};
        end
        if (fire) begin
            r_res <= core_res;
        end
    end

    assign o_res_valid        = r_res_valid;
    assign o_rom_byte_address = r_res.rom_byte_address;
    assign o_rom_hit          = r_res.rom_hit;
    assign o_game_mode        = r_res.game_mode;

    // A result that is not a ROM hit carries a zero address.
    `MCBM_ASSERT_IMPL(a_miss_zero_addr, r_res_valid && !r_res.rom_hit,
        r_res.rom_byte_address == '0)
    // A held result is never dropped.
    `MCBM_ASSERT_NEXT(a_res_held, r_res_valid && i_res_stall, r_res_valid)
    // A waiting request is never dropped.
    `MCBM_ASSERT_NEXT(a_req_held, r_req_valid && !out_free, r_req_valid)
    // Game mode, once reported, stays set on later results.
    `MCBM_ASSERT_NEXT(a_game_sticky, fire && core_res.game_mode,
        !fire || core_res.game_mode)

endmodule
